FILE: rtl/mersenne_factor_candidate_sieve_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Mersenne factor candidate sieve
// Concurrent checks that vanish when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef MERSENNE_FACTOR_CANDIDATE_SIEVE_DEFINES_SVH
`define MERSENNE_FACTOR_CANDIDATE_SIEVE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define MFCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sieve check failed");
// Next-cycle implication
`define MFCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sieve check failed");
`else
`define MFCS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MFCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/mfcs_pkg.sv
// ----------------------------------------------------------------------------
// mfcs_pkg
// Constants, prime table and controller command type of the candidate sieve.
// ----------------------------------------------------------------------------
`default_nettype none

package mfcs_pkg;

  localparam int NUM_PRIMES = 64;
  localparam int POS_W      = 9;   // holds every prime of the table
  localparam int K_W        = 63;
  localparam int P_W        = 31;
  localparam int ACT_W      = 7;
  localparam int BIT_W      = 6;   // indexes the bits of start_k
  localparam int IDX_W      = 2;

  // Largest key that the search has to try: largest prime less one
  localparam logic [POS_W-1:0] MAX_KEY = 9'd312;
  localparam logic [BIT_W-1:0] TOP_BIT = 6'd62;

  // Register indexes
  localparam logic [IDX_W-1:0] CFG_EXPONENT = 2'd0;
  localparam logic [IDX_W-1:0] CFG_ACTIVE   = 2'd1;

  // The first odd primes
  localparam logic [POS_W-1:0] PRIME_TAB [NUM_PRIMES] = '{
    9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,  9'd23,
    9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,  9'd59,
    9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,  9'd97,
    9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131, 9'd137,
    9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173, 9'd179,
    9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223, 9'd227,
    9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263, 9'd269,
    9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311, 9'd313
  };

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             capture;  // latch start_k, clear the remainders
    logic             shift;    // fold one bit into every remainder
    logic [BIT_W-1:0] bit_idx;
    logic             prep;     // fix positions, set up the key search
    logic             search;   // try one key value in every lane
    logic [POS_W-1:0] k;
    logic             advance;  // test current k and step positions
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/mfcs_ctrl.sv
// ----------------------------------------------------------------------------
// mfcs_ctrl
// Sequencer for restart and advance requests and the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module mfcs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          mode_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output mfcs_pkg::cmd_t     cmd_o
);
  import mfcs_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOAD   = 2'd1;
  localparam logic [1:0] ST_PREP   = 2'd2;
  localparam logic [1:0] ST_SEARCH = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [POS_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    cmd_o.bit_idx = cnt_q[BIT_W-1:0];
    cmd_o.k     = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept && mode_i) begin
          cmd_o.advance = 1'b1;
          out_valid_d   = 1'b1;
        end else if (accept) begin
          cmd_o.capture = 1'b1;
          cnt_d         = {{(POS_W-BIT_W){1'b0}}, TOP_BIT};
          state_d       = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.shift = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_PREP;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = {{(POS_W-1){1'b0}}, 1'b1};
        state_d    = ST_SEARCH;
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        if (cnt_q == MAX_KEY) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mfcs_datapath.sv
// ----------------------------------------------------------------------------
// mfcs_datapath
// One lane per prime: position, key, and bit-serial residue arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module mfcs_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mfcs_pkg::cmd_t                cmd_i,
  input  wire logic [mfcs_pkg::K_W-1:0]      start_k_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [mfcs_pkg::IDX_W-1:0]    cfg_idx_i,
  input  wire logic [mfcs_pkg::P_W-1:0]      cfg_wdata_i,
  output logic                               survivor_o
);
  import mfcs_pkg::*;

  logic [P_W-1:0]   exp_q;
  logic [ACT_W-1:0] active_q;
  logic [K_W-1:0]   k_q;
  logic             survivor_q;
  logic             k_bit, p_bit;
  logic [NUM_PRIMES-1:0] hit;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q    <= 31'd3;
      active_q <= 7'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EXPONENT: exp_q    <= cfg_wdata_i;
        CFG_ACTIVE:   active_q <= cfg_wdata_i[ACT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Latch the start multiplier
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      k_q <= start_k_i;
    end
  end

  // Serial bits, most significant first; the exponent fills the low bits
  assign k_bit = k_q[cmd_i.bit_idx];
  assign p_bit = (cmd_i.bit_idx < BIT_W'(P_W)) ? exp_q[cmd_i.bit_idx[4:0]] : 1'b0;

  for (genvar i = 0; i < NUM_PRIMES; i++) begin : g_lane
    logic [POS_W-1:0] pos_q, pm_q, acc_q, key_q;
    logic [POS_W:0]   k_dbl, p_dbl, t_dbl, a_inc, a_sum;
    logic [POS_W-1:0] k_red, p_red, tp, acc0, acc_nx;

    // Remainder steps: double plus bit, reduce once
    assign k_dbl = {pos_q, k_bit};
    assign p_dbl = {pm_q, p_bit};
    assign k_red = (k_dbl >= {1'b0, PRIME_TAB[i]}) ? POS_W'(k_dbl - PRIME_TAB[i])
                                                  : k_dbl[POS_W-1:0];
    assign p_red = (p_dbl >= {1'b0, PRIME_TAB[i]}) ? POS_W'(p_dbl - PRIME_TAB[i])
                                                  : p_dbl[POS_W-1:0];

    // 2p mod n, and the residue of 2p+1
    assign t_dbl = {pm_q, 1'b0};
    assign tp    = (t_dbl >= {1'b0, PRIME_TAB[i]}) ? POS_W'(t_dbl - PRIME_TAB[i])
                                                  : t_dbl[POS_W-1:0];
    assign a_inc = {1'b0, tp} + 1'b1;
    assign acc0  = (a_inc >= {1'b0, PRIME_TAB[i]}) ? POS_W'(a_inc - PRIME_TAB[i])
                                                  : a_inc[POS_W-1:0];

    // Running residue of 2pk+1 during the key search
    assign a_sum  = {1'b0, acc_q} + {1'b0, pm_q};
    assign acc_nx = (a_sum >= {1'b0, PRIME_TAB[i]}) ? POS_W'(a_sum - PRIME_TAB[i])
                                                   : a_sum[POS_W-1:0];

    assign hit[i] = (ACT_W'(i) < active_q) && (key_q != '0) && (pos_q == key_q);

    // Position: reset to one, rebuilt by a restart, stepped round on advance
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pos_q <= POS_W'(1);
      end else if (cmd_i.capture) begin
        pos_q <= '0;
      end else if (cmd_i.shift) begin
        pos_q <= k_red;
      end else if (cmd_i.prep && pos_q == '0) begin
        pos_q <= PRIME_TAB[i];
      end else if (cmd_i.advance) begin
        pos_q <= (pos_q >= PRIME_TAB[i]) ? POS_W'(1) : pos_q + 1'b1;
      end
    end

    // Key search working registers
    always_ff @(posedge clk_i) begin
      if (cmd_i.capture) begin
        pm_q <= '0;
      end else if (cmd_i.shift) begin
        pm_q <= p_red;
      end else if (cmd_i.prep) begin
        pm_q  <= tp;
        acc_q <= acc0;
        key_q <= '0;
      end else if (cmd_i.search) begin
        acc_q <= acc_nx;
        if (acc_q == '0 && key_q == '0) begin
          key_q <= cmd_i.k;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      survivor_q <= ~|hit;
    end
  end

  assign survivor_o = survivor_q;

endmodule

`default_nettype wire

FILE: rtl/mersenne_factor_candidate_sieve.sv
// ----------------------------------------------------------------------------
// mersenne_factor_candidate_sieve
// Sieve of trial factor candidates 2pk+1 against the first 64 odd primes.
// ----------------------------------------------------------------------------
// Use: set mersenne_exponent (index 0) and active_primes (index 1) on the
// write port, then send a restart request (mode 0) with start_k. A restart
// gives no result and keeps the input busy while LOAD folds start_k and p
// into every lane bit by bit, PREP prepares, and SEARCH tries every key up
// to the largest prime less one in every lane in parallel. Each advance
// request (mode 1) then gives one survivor result in the cycle after
// acceptance, and advances can follow one per cycle while the receiver
// takes results. A single output register holds the result: when the
// receiver stalls, that request waits in it and no further request is
// taken until it leaves. After reset every position is one, the exponent is
// three and all 64 primes are active; keys exist only after a restart.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mersenne_factor_candidate_sieve_defines.svh"

module mersenne_factor_candidate_sieve (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         mode_i,
  input  wire logic [mfcs_pkg::K_W-1:0]     start_k_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              survivor_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [mfcs_pkg::IDX_W-1:0]   cfg_idx_i,
  input  wire logic [mfcs_pkg::P_W-1:0]     cfg_wdata_i
);
  import mfcs_pkg::*;

  cmd_t cmd;

  mfcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  mfcs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .start_k_i   (start_k_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .survivor_o  (survivor_o)
  );

  // Busy lanes never take a request
  `MFCS_ASSERT_SAME(a_busy_no_ready, clk_i, rst_ni,
                    cmd.shift || cmd.prep || cmd.search, !in_ready_o)
  // A restart blocks the input on the next cycle
  `MFCS_ASSERT_NEXT(a_restart_blocks, clk_i, rst_ni,
                    in_valid_i && in_ready_o && !mode_i, !in_ready_o)
  // An advance shows a result on the next cycle
  `MFCS_ASSERT_NEXT(a_advance_result, clk_i, rst_ni,
                    in_valid_i && in_ready_o && mode_i, out_valid_o)

endmodule

`default_nettype wire
